@@ design/stack_machine_execute_assert.svh @@
// assertion macros for the stack machine execute block
`ifndef STACK_MACHINE_EXECUTE_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define SME_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");

// antecedent in one cycle implies consequent in the next
`define SME_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

@@ design/sme_pkg.sv @@
// package with opcodes, status codes and defaults of the stack machine execute block
`default_nettype none
package sme_pkg;

   localparam int SME_STACK_DEPTH = 64;
   localparam int SME_PC_WIDTH    = 16;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 1;

   typedef enum logic [3:0] {
      OP_READ   = 4'd0,
      OP_WRITE  = 4'd1,
      OP_ADD    = 4'd2,
      OP_DUP    = 4'd3,
      OP_PUSH   = 4'd4,
      OP_JUMPIF = 4'd5,
      OP_OVER   = 4'd6,
      OP_SWAP   = 4'd7,
      OP_MUL    = 4'd8
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_UNDER = 2'd1,
      STATUS_OVER  = 2'd2
   } status_type;

endpackage
`default_nettype wire

@@ design/stack_machine_execute.sv @@
// stack machine execute stage: top two words in registers, the rest in a stack memory
//
//  channel | ports                      | payload (lowest bit up)
//  --------+----------------------------+-----------------------------------------------
//  request | req_tvalid/tready/tdata    | opcode 4, immediate 32, read_value 32, pad 4
//  result  | rsp_tvalid/tready/tdata/tuser | write_value 32, next_pc 16, stack_depth 7,
//          |                            | status 2, pad 7; tuser: write_valid
//
// one request per cycle while results are taken; a write, jumpif, add or mul that leaves two
// or more words holds off the next request while the second register refills from memory
// a result waiting in the result register holds off the next request until it is taken
// reset is synchronous and clears count, program counter and control; no clearing pass
// the stack memory is never read below the live count, so it needs no reset
`default_nettype none
module stack_machine_execute #(
   parameter int STACK_DEPTH = sme_pkg::SME_STACK_DEPTH,
   parameter int PC_WIDTH    = sme_pkg::SME_PC_WIDTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // opcode [3:0], immediate [35:4], read_value [67:36], zero pad [71:68]
   input  wire logic [sme_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // write_value [31:0], next_pc [47:32], stack_depth [54:48], status [56:55], pad [63:57]
   output logic [sme_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // write_valid [0]
   output logic [sme_pkg::RSP_USER_W-1:0]       rsp_tuser
);
   import sme_pkg::*;

   localparam int CW        = $clog2(STACK_DEPTH + 1);
   localparam int MEM_DEPTH = STACK_DEPTH - 2;
   localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int DW        = (CW > 7) ? CW : 7;
   localparam int PW        = (PC_WIDTH > 16) ? PC_WIDTH : 16;

   typedef enum logic {
      ST_IDLE,
      ST_FILL
   } state_type;

   state_type             state_ff, state_in;
   logic [31:0]           top_ff, top_in;
   logic [31:0]           second_ff, second_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [PC_WIDTH-1:0]   pc_ff, pc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_value_ff, rsp_value_in;
   logic [PC_WIDTH-1:0]   rsp_pc_ff, rsp_pc_in;
   logic [CW-1:0]         rsp_depth_ff, rsp_depth_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  rsp_wvalid_ff, rsp_wvalid_in;

   // stack memory below the two top registers
   logic [31:0]           stack_mem [MEM_DEPTH];
   logic [31:0]           mem_rd_ff;
   logic                  mem_we;
   logic                  mem_re;
   logic [AW-1:0]         mem_waddr;
   logic [AW-1:0]         mem_raddr;

   // request fields
   opcode_type            opcode;
   logic [31:0]           immediate;
   logic [31:0]           read_value;
   logic                  accept;
   logic [1:0]            need;
   logic                  grow;
   status_type            status;
   logic [31:0]           push_value;
   logic [31:0]           product;
   logic [PC_WIDTH-1:0]   pc_next;
   logic                  fill;
   logic [CW-1:0]         count_m2;
   logic [CW-1:0]         count_m3;
   logic [DW-1:0]         depth_ext;
   logic [PW-1:0]         pc_ext;

   assign opcode     = opcode_type'(req_tdata[3:0]);
   assign immediate  = req_tdata[35:4];
   assign read_value = req_tdata[67:36];

   // accept only when idle and the result register can take a new result
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign count_m2 = count_ff - CW'(2);
   assign count_m3 = count_ff - CW'(3);
   assign product  = top_ff * second_ff;
   assign pc_next  = pc_ff + PC_WIDTH'(1);

   // words needed and growth per opcode
   always_comb begin
      need = 2'd0;
      grow = 1'b0;
      case (opcode)
         OP_READ, OP_PUSH: begin
            grow = 1'b1;
         end
         OP_WRITE, OP_JUMPIF: begin
            need = 2'd1;
         end
         OP_ADD, OP_MUL, OP_SWAP: begin
            need = 2'd2;
         end
         OP_DUP: begin
            need = 2'd1;
            grow = 1'b1;
         end
         OP_OVER: begin
            need = 2'd2;
            grow = 1'b1;
         end
         default: begin
            need = 2'd0;
            grow = 1'b0;
         end
      endcase
   end

   // underflow is checked before overflow
   always_comb begin
      if (count_ff < CW'(need)) begin
         status = STATUS_UNDER;
      end else if (grow && (count_ff >= CW'(STACK_DEPTH))) begin
         status = STATUS_OVER;
      end else begin
         status = STATUS_OK;
      end
   end

   // word pushed by the growing opcodes
   always_comb begin
      case (opcode)
         OP_READ: push_value = read_value;
         OP_PUSH: push_value = immediate;
         OP_DUP:  push_value = top_ff;
         OP_OVER: push_value = second_ff;
         default: push_value = immediate;
      endcase
   end

   // execute: next values of the top registers, count, pc and memory access
   always_comb begin
      state_in      = state_ff;
      top_in        = top_ff;
      second_in     = second_ff;
      count_in      = count_ff;
      pc_in         = pc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_pc_in     = rsp_pc_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;
      rsp_wvalid_in = rsp_wvalid_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = count_m2[AW-1:0];
      mem_raddr     = count_m3[AW-1:0];
      fill          = 1'b0;

      // refill of the second register from the memory read
      if (state_ff == ST_FILL) begin
         second_in = mem_rd_ff;
         state_in  = ST_IDLE;
      end

      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_wvalid_in = 1'b0;
         rsp_value_in  = 32'd0;
         rsp_pc_in     = pc_ff;
         rsp_depth_in  = count_ff;
         if (status == STATUS_OK) begin
            pc_in = pc_next;
            case (opcode)
               OP_READ, OP_PUSH, OP_DUP, OP_OVER: begin
                  mem_we    = (count_ff >= CW'(2));
                  second_in = top_ff;
                  top_in    = push_value;
                  count_in  = count_ff + CW'(1);
               end
               OP_WRITE, OP_JUMPIF, OP_ADD, OP_MUL: begin
                  fill     = (count_ff >= CW'(3));
                  mem_re   = fill;
                  count_in = count_ff - CW'(1);
                  case (opcode)
                     OP_ADD:  top_in = top_ff + second_ff;
                     OP_MUL:  top_in = product;
                     default: top_in = second_ff;
                  endcase
                  if (opcode == OP_WRITE) begin
                     rsp_wvalid_in = 1'b1;
                     rsp_value_in  = top_ff;
                  end
                  if ((opcode == OP_JUMPIF) && !top_ff[31]) begin
                     pc_in = immediate[PC_WIDTH-1:0];
                  end
                  if (fill) begin
                     state_in = ST_FILL;
                  end
               end
               OP_SWAP: begin
                  top_in    = second_ff;
                  second_in = top_ff;
               end
               default: begin
                  top_in = top_ff;
               end
            endcase
            rsp_pc_in    = pc_in;
            rsp_depth_in = count_in;
         end
      end
   end

   // state, stack registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff        <= top_in;
      second_ff     <= second_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
      rsp_wvalid_ff <= rsp_wvalid_in;
   end

   // stack memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= second_ff;
      end
      if (mem_re) begin
         mem_rd_ff <= stack_mem[mem_raddr];
      end
   end

   // result packing, narrow fields masked to their widths
   assign depth_ext  = DW'(rsp_depth_ff);
   assign pc_ext     = PW'(rsp_pc_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff, depth_ext[6:0], pc_ext[15:0], rsp_value_ff};
   assign rsp_tuser  = rsp_wvalid_ff;

   `include "stack_machine_execute_assert.svh"

   `SME_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(STACK_DEPTH))
   `SME_ASSERT_NEXT(a_error_keeps_state, clock, reset, accept && (status != STATUS_OK), $stable(count_ff) && $stable(pc_ff))
   `SME_ASSERT_NEXT(a_fill_follows_pop, clock, reset, accept && fill, (state_ff == ST_FILL) && !req_tready)

endmodule
`default_nettype wire
